>>> src/fft_pkg.sv
// Shared types, constants and twiddle table for the radix-2 FFT block.
`timescale 1ns / 1ps
package fft_pkg;

   // largest transform is 2^MAX_LOG2_POINTS points; twiddles are Q1.15
   localparam int MAX_LOG2_POINTS = 6;
   localparam int TWIDDLE_WIDTH   = 16;

   // controller states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FILL,
      ST_RD_B,
      ST_RD_A,
      ST_WR_A,
      ST_WR_B,
      ST_OUT_RD,
      ST_OUT_SEND
   } state_type;

   // memory address source selection
   typedef enum logic [1:0] {
      ADDR_LOAD,
      ADDR_BFLY_A,
      ADDR_BFLY_B,
      ADDR_OUT
   } addr_sel_type;

   // controller to datapath command
   typedef struct packed {
      logic         load_we;
      logic         zero_we;
      addr_sel_type addr_sel;
      logic         b_capture;
      logic         a_capture;
      logic         wr_a;
      logic         wr_b;
      logic         out_fire;
      logic         out_last;
   } dp_cmd_type;

   // Q1.15 twiddle table, W[k] = cos(2 pi k/64) - j sin(2 pi k/64)
   function automatic logic signed [15:0] tw_re_fn(input logic [4:0] k);
      logic signed [15:0] c;
      case (k)
         5'd0:  c = 16'sd32767;  5'd1:  c = 16'sd32610;  5'd2:  c = 16'sd32138;
         5'd3:  c = 16'sd31357;  5'd4:  c = 16'sd30274;  5'd5:  c = 16'sd28899;
         5'd6:  c = 16'sd27246;  5'd7:  c = 16'sd25330;  5'd8:  c = 16'sd23170;
         5'd9:  c = 16'sd20788;  5'd10: c = 16'sd18205;  5'd11: c = 16'sd15447;
         5'd12: c = 16'sd12540;  5'd13: c = 16'sd9512;   5'd14: c = 16'sd6393;
         5'd15: c = 16'sd3212;   5'd16: c = 16'sd0;      5'd17: c = -16'sd3212;
         5'd18: c = -16'sd6393;  5'd19: c = -16'sd9512;  5'd20: c = -16'sd12540;
         5'd21: c = -16'sd15447; 5'd22: c = -16'sd18205; 5'd23: c = -16'sd20788;
         5'd24: c = -16'sd23170; 5'd25: c = -16'sd25330; 5'd26: c = -16'sd27246;
         5'd27: c = -16'sd28899; 5'd28: c = -16'sd30274; 5'd29: c = -16'sd31357;
         5'd30: c = -16'sd32138; default: c = -16'sd32610;
      endcase
      return c;
   endfunction

   function automatic logic signed [15:0] tw_im_fn(input logic [4:0] k);
      logic signed [15:0] s;
      case (k)
         5'd0:  s = 16'sd0;      5'd1:  s = -16'sd3212;  5'd2:  s = -16'sd6393;
         5'd3:  s = -16'sd9512;  5'd4:  s = -16'sd12540; 5'd5:  s = -16'sd15447;
         5'd6:  s = -16'sd18205; 5'd7:  s = -16'sd20788; 5'd8:  s = -16'sd23170;
         5'd9:  s = -16'sd25330; 5'd10: s = -16'sd27246; 5'd11: s = -16'sd28899;
         5'd12: s = -16'sd30274; 5'd13: s = -16'sd31357; 5'd14: s = -16'sd32138;
         5'd15: s = -16'sd32610; 5'd16: s = -16'sd32767; 5'd17: s = -16'sd32610;
         5'd18: s = -16'sd32138; 5'd19: s = -16'sd31357; 5'd20: s = -16'sd30274;
         5'd21: s = -16'sd28899; 5'd22: s = -16'sd27246; 5'd23: s = -16'sd25330;
         5'd24: s = -16'sd23170; 5'd25: s = -16'sd20788; 5'd26: s = -16'sd18205;
         5'd27: s = -16'sd15447; 5'd28: s = -16'sd12540; 5'd29: s = -16'sd9512;
         5'd30: s = -16'sd6393;  default: s = -16'sd3212;
      endcase
      return s;
   endfunction

endpackage

>>> src/radix2_fft_in_place.sv
// Top level of the in-place radix-2 FFT block.
`timescale 1ns / 1ps
// Usage:
//  Samples enter on req_sample_re/req_sample_im with start; a sample is
//  taken when start is high and busy is low. req_frame_last ends a frame.
//  Samples past N before the last one are dropped; missing ones read as 0.
//  After the last sample the block zero-fills the rest of memory, then
//  runs log2(N) stages of N/2 butterflies, each reading B, reading A,
//  writing A' and writing B' through the single-port sample memory, then
//  emits N bins in natural order, never back to back, each marked by
//  rsp_valid for one cycle. The receiver cannot stall. rsp_last_bin
//  marks bin N-1. Throughput is bounded by the one memory port.
//  csr_log2_points (N = 2^value, value clamped to 1..6) is written on
//  csr_valid and csr_ready; the user must write it only while idle, the
//  block does not enforce this. Reset sets it to 6 and empties the frame.
module radix2_fft_in_place #(
   parameter int SAMPLE_WIDTH    = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_re,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_im,
   input  logic                         req_frame_last,
   output logic                         rsp_valid,
   output logic signed [SAMPLE_WIDTH+fft_pkg::MAX_LOG2_POINTS-1:0] rsp_bin_re,
   output logic signed [SAMPLE_WIDTH+fft_pkg::MAX_LOG2_POINTS-1:0] rsp_bin_im,
   output logic [5:0]                   rsp_bin_index,
   output logic                         rsp_last_bin,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [2:0]                   csr_log2_points
);

   localparam int AW = fft_pkg::MAX_LOG2_POINTS;

   logic [2:0] log2_ff;
   fft_pkg::dp_cmd_type cmd;
   logic [AW-1:0] load_addr, addr_a, addr_b, out_addr, out_index;
   logic [AW-2:0] tw_index;

   assign csr_ready = 1'b1;

   // length register
   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ff <= 3'd6;
      end else if (csr_valid && csr_ready) begin
         log2_ff <= csr_log2_points;
      end
   end

   fft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .frame_last (req_frame_last),
      .log2_cfg   (log2_ff),
      .busy       (busy),
      .cmd        (cmd),
      .load_addr  (load_addr),
      .addr_a     (addr_a),
      .addr_b     (addr_b),
      .out_addr   (out_addr),
      .out_index  (out_index),
      .tw_index   (tw_index)
   );

   fft_dp #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .load_addr (load_addr),
      .addr_a    (addr_a),
      .addr_b    (addr_b),
      .out_addr  (out_addr),
      .out_index (out_index),
      .tw_index  (tw_index),
      .sample_re (req_sample_re),
      .sample_im (req_sample_im),
      .out_valid (rsp_valid),
      .out_re    (rsp_bin_re),
      .out_im    (rsp_bin_im),
      .out_bin   (rsp_bin_index),
      .out_last  (rsp_last_bin)
   );

endmodule

>>> src/fft_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module fft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write-first is not needed; read returns old data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/fft_ctrl.sv
// Sequencer for loading, butterfly stages and bit-reversed readout.
`timescale 1ns / 1ps
module fft_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 frame_last,
   input  logic [2:0]                           log2_cfg,
   output logic                                 busy,
   output fft_pkg::dp_cmd_type                  cmd,
   output logic [fft_pkg::MAX_LOG2_POINTS-1:0]  load_addr,
   output logic [fft_pkg::MAX_LOG2_POINTS-1:0]  addr_a,
   output logic [fft_pkg::MAX_LOG2_POINTS-1:0]  addr_b,
   output logic [fft_pkg::MAX_LOG2_POINTS-1:0]  out_addr,
   output logic [fft_pkg::MAX_LOG2_POINTS-1:0]  out_index,
   output logic [fft_pkg::MAX_LOG2_POINTS-2:0]  tw_index
);

   localparam int MAX_LOG2_POINTS = fft_pkg::MAX_LOG2_POINTS;
   localparam int AW = MAX_LOG2_POINTS;
   localparam int LW = $clog2(MAX_LOG2_POINTS + 1);

   fft_pkg::state_type state_ff, state_in;
   logic [AW:0]   count_ff, count_in;       // samples loaded / fill pointer
   logic [LW-1:0] len_ff, len_in;           // transform log2 length
   logic [LW-1:0] stage_ff, stage_in;       // 1..L
   logic [AW-1:0] bfly_ff, bfly_in;         // butterfly counter within stage
   logic [AW-1:0] k_ff, k_in;               // output bin counter

   logic [LW-1:0] len_clamp;
   logic [AW:0]   n_pts;
   logic [AW-1:0] half_m1;
   logic [AW-1:0] m_idx, g_idx, a_addr, g_rev;
   logic [AW:0]   g_dbl;
   logic          accept, bfly_last;

   assign accept = start && (state_ff == fft_pkg::ST_LOAD);
   assign busy = (state_ff != fft_pkg::ST_LOAD);

   // clamp length register into 1..MAX
   always_comb begin
      if (log2_cfg == 3'd0) begin
         len_clamp = LW'(1);
      end else if (32'(log2_cfg) > MAX_LOG2_POINTS) begin
         len_clamp = LW'(MAX_LOG2_POINTS);
      end else begin
         len_clamp = LW'(log2_cfg);
      end
   end

   // active length: config during load, latched after
   logic [LW-1:0] len_use;
   assign len_use = (state_ff == fft_pkg::ST_LOAD) ? len_clamp : len_ff;
   assign n_pts = (AW + 1)'(1) << len_use;

   // butterfly address: half = N >> stage, bfly splits into group and m
   logic [AW-1:0] half;
   assign half = AW'(n_pts >> stage_ff);
   assign half_m1 = half - AW'(1);
   assign m_idx = bfly_ff & half_m1;
   assign g_idx = AW'(bfly_ff >> (len_ff - stage_ff));
   assign a_addr = AW'((g_idx << (len_ff - stage_ff + LW'(1))) | m_idx);
   assign addr_a = a_addr;
   assign addr_b = a_addr | half;
   assign bfly_last = (32'(bfly_ff) == ((32'(n_pts) >> 1) - 1));

   // twiddle index: bitrev over L bits of 2g, scaled up to full table
   assign g_dbl = {g_idx, 1'b0};
   always_comb begin
      g_rev = '0;
      for (int i = 0; i < AW; i++) begin
         if (LW'(i) < len_ff) begin
            g_rev[len_ff - LW'(1) - LW'(i)] = g_dbl[i];
         end
      end
   end
   assign tw_index = (AW - 1)'(g_rev << (LW'(AW) - len_ff));

   // bit-reversed readout address
   always_comb begin
      out_addr = '0;
      for (int i = 0; i < AW; i++) begin
         if (LW'(i) < len_ff) begin
            out_addr[len_ff - LW'(1) - LW'(i)] = k_ff[i];
         end
      end
   end
   assign out_index = k_ff;
   assign load_addr = count_ff[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      len_in = len_ff;
      stage_in = stage_ff;
      bfly_in = bfly_ff;
      k_in = k_ff;
      unique case (state_ff)
         fft_pkg::ST_LOAD: begin
            if (accept) begin
               if (count_ff < n_pts) begin
                  count_in = count_ff + (AW + 1)'(1);
               end
               if (frame_last) begin
                  len_in = len_clamp;
                  state_in = fft_pkg::ST_FILL;
               end
            end
         end
         fft_pkg::ST_FILL: begin
            if (count_ff >= n_pts) begin
               state_in = fft_pkg::ST_RD_B;
               count_in = '0;
               stage_in = LW'(1);
               bfly_in = '0;
            end else begin
               count_in = count_ff + (AW + 1)'(1);
            end
         end
         fft_pkg::ST_RD_B: state_in = fft_pkg::ST_RD_A;
         fft_pkg::ST_RD_A: state_in = fft_pkg::ST_WR_A;
         fft_pkg::ST_WR_A: state_in = fft_pkg::ST_WR_B;
         fft_pkg::ST_WR_B: begin
            if (bfly_last) begin
               bfly_in = '0;
               if (stage_ff == len_ff) begin
                  state_in = fft_pkg::ST_OUT_RD;
                  k_in = '0;
               end else begin
                  stage_in = stage_ff + LW'(1);
                  state_in = fft_pkg::ST_RD_B;
               end
            end else begin
               bfly_in = bfly_ff + AW'(1);
               state_in = fft_pkg::ST_RD_B;
            end
         end
         fft_pkg::ST_OUT_RD: state_in = fft_pkg::ST_OUT_SEND;
         fft_pkg::ST_OUT_SEND: begin
            if ((AW + 1)'(k_ff) == n_pts - (AW + 1)'(1)) begin
               state_in = fft_pkg::ST_LOAD;
            end else begin
               k_in = k_ff + AW'(1);
               state_in = fft_pkg::ST_OUT_RD;
            end
         end
         default: state_in = fft_pkg::ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.addr_sel = fft_pkg::ADDR_LOAD;
      unique case (state_ff)
         fft_pkg::ST_LOAD: cmd.load_we = accept && (count_ff < n_pts);
         fft_pkg::ST_FILL: cmd.zero_we = (count_ff < n_pts);
         fft_pkg::ST_RD_B: cmd.addr_sel = fft_pkg::ADDR_BFLY_B;
         fft_pkg::ST_RD_A: begin
            cmd.addr_sel = fft_pkg::ADDR_BFLY_A;
            cmd.b_capture = 1'b1;
         end
         fft_pkg::ST_WR_A: begin
            cmd.addr_sel = fft_pkg::ADDR_BFLY_A;
            cmd.a_capture = 1'b1;
            cmd.wr_a = 1'b1;
         end
         fft_pkg::ST_WR_B: begin
            cmd.addr_sel = fft_pkg::ADDR_BFLY_B;
            cmd.wr_b = 1'b1;
         end
         fft_pkg::ST_OUT_RD: cmd.addr_sel = fft_pkg::ADDR_OUT;
         fft_pkg::ST_OUT_SEND: begin
            cmd.addr_sel = fft_pkg::ADDR_OUT;
            cmd.out_fire = 1'b1;
            cmd.out_last = ((AW + 1)'(k_ff) == n_pts - (AW + 1)'(1));
         end
         default: cmd.addr_sel = fft_pkg::ADDR_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fft_pkg::ST_LOAD;
         count_ff <= '0;
         len_ff <= LW'(MAX_LOG2_POINTS);
         stage_ff <= LW'(1);
         bfly_ff <= '0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= (state_in == fft_pkg::ST_LOAD && state_ff == fft_pkg::ST_OUT_SEND)
                     ? '0 : count_in;
         len_ff <= len_in;
         stage_ff <= stage_in;
         bfly_ff <= bfly_in;
         k_ff <= k_in;
      end
   end

endmodule

>>> src/fft_dp.sv
// Datapath: sample memory, complex butterfly and result register.
`timescale 1ns / 1ps
module fft_dp #(
   parameter int SAMPLE_WIDTH    = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  fft_pkg::dp_cmd_type                        cmd,
   input  logic [fft_pkg::MAX_LOG2_POINTS-1:0]        load_addr,
   input  logic [fft_pkg::MAX_LOG2_POINTS-1:0]        addr_a,
   input  logic [fft_pkg::MAX_LOG2_POINTS-1:0]        addr_b,
   input  logic [fft_pkg::MAX_LOG2_POINTS-1:0]        out_addr,
   input  logic [fft_pkg::MAX_LOG2_POINTS-1:0]        out_index,
   input  logic [fft_pkg::MAX_LOG2_POINTS-2:0]        tw_index,
   input  logic signed [SAMPLE_WIDTH-1:0]             sample_re,
   input  logic signed [SAMPLE_WIDTH-1:0]             sample_im,
   output logic                                       out_valid,
   output logic signed [SAMPLE_WIDTH+fft_pkg::MAX_LOG2_POINTS-1:0] out_re,
   output logic signed [SAMPLE_WIDTH+fft_pkg::MAX_LOG2_POINTS-1:0] out_im,
   output logic [5:0]                                 out_bin,
   output logic                                       out_last
);

   localparam int AW = fft_pkg::MAX_LOG2_POINTS;
   localparam int TWW = fft_pkg::TWIDDLE_WIDTH;
   localparam int WW = SAMPLE_WIDTH + AW;
   localparam int TF = TWW - 1;
   localparam int PW = WW + TWW;
   localparam logic signed [WW+1:0] WMAX = (WW + 2)'((64'sd1 <<< (WW - 1)) - 1);
   localparam logic signed [WW+1:0] WMIN = -WMAX - (WW + 2)'(1);

   logic [AW-1:0]        addr;
   logic                 we;
   logic [2*WW-1:0]      wdata, rdata;
   logic signed [WW-1:0] rd_re, rd_im;

   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [WW+1:0] t_re, t_im;
   logic signed [WW+1:0] a_re_ff, a_im_ff, t_re_ff, t_im_ff;
   logic signed [TWW-1:0] w_re, w_im;
   logic signed [WW-1:0] sum_re, sum_im, dif_re, dif_im;

   // twiddle lookup
   assign w_re = fft_pkg::tw_re_fn(tw_index);
   assign w_im = fft_pkg::tw_im_fn(tw_index);

   function automatic logic signed [WW+1:0] rnd(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] q;
      q = (p + PW'(64'sd1 <<< (TF - 1))) >>> TF;
      return (WW + 2)'(q);
   endfunction

   function automatic logic signed [WW-1:0] sat(input logic signed [WW+1:0] v);
      if (v > WMAX) return WMAX[WW-1:0];
      if (v < WMIN) return WMIN[WW-1:0];
      return v[WW-1:0];
   endfunction

   // address and write mux
   always_comb begin
      unique case (cmd.addr_sel)
         fft_pkg::ADDR_LOAD:   addr = load_addr;
         fft_pkg::ADDR_BFLY_A: addr = addr_a;
         fft_pkg::ADDR_BFLY_B: addr = addr_b;
         default:              addr = out_addr;
      endcase
   end

   // A' from A on the read port and T from the products; B' from held A and T
   assign sum_re = sat((WW + 2)'(rd_re) + t_re);
   assign sum_im = sat((WW + 2)'(rd_im) + t_im);
   assign dif_re = sat(a_re_ff - t_re_ff);
   assign dif_im = sat(a_im_ff - t_im_ff);

   always_comb begin
      we = cmd.load_we | cmd.zero_we | cmd.wr_a | cmd.wr_b;
      wdata = '0;
      if (cmd.load_we) begin
         wdata = {WW'(sample_re), WW'(sample_im)};
      end else if (cmd.wr_a) begin
         wdata = {sum_re, sum_im};
      end else if (cmd.wr_b) begin
         wdata = {dif_re, dif_im};
      end
   end

   fft_ram #(.WIDTH(2 * WW), .DEPTH(1 << AW)) u_ram (
      .clock (clock),
      .we    (we),
      .addr  (addr),
      .wdata (wdata),
      .rdata (rdata)
   );

   assign rd_re = rdata[2*WW-1:WW];
   assign rd_im = rdata[WW-1:0];

   // multiply B by the twiddle as it leaves memory
   always_ff @(posedge clock) begin
      if (cmd.b_capture) begin
         p_rr_ff <= PW'(rd_re) * PW'(w_re);
         p_ii_ff <= PW'(rd_im) * PW'(w_im);
         p_ri_ff <= PW'(rd_re) * PW'(w_im);
         p_ir_ff <= PW'(rd_im) * PW'(w_re);
      end
   end

   assign t_re = rnd(p_rr_ff) - rnd(p_ii_ff);
   assign t_im = rnd(p_ri_ff) + rnd(p_ir_ff);

   // hold A and T for the B' write
   always_ff @(posedge clock) begin
      if (cmd.a_capture) begin
         a_re_ff <= (WW + 2)'(rd_re);
         a_im_ff <= (WW + 2)'(rd_im);
         t_re_ff <= t_re;
         t_im_ff <= t_im;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= cmd.out_fire;
      end
      if (cmd.out_fire) begin
         out_re <= rd_re;
         out_im <= rd_im;
         out_bin <= 6'(out_index);
         out_last <= cmd.out_last;
      end
   end

endmodule

>>> src/fft_checker.sv
// Port-level checker for the FFT block, bound to the top level.
`timescale 1ns / 1ps
module fft_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last_bin
);

   // no results while accepting samples
   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) |-> !rsp_valid) else $error("result while idle");

   // results are never back to back
   a_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("results adjacent");

   // last bin ends the run
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_bin |-> !busy) else $error("busy after last bin");

endmodule

bind radix2_fft_in_place fft_checker u_fft_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_last_bin (rsp_last_bin)
);
